[src/ffba_pkg.sv]
package ffba_pkg;

  localparam int WORD_W = 32;
  localparam int LOG_W  = 5;
  localparam int SIZE_W = 11;
  localparam int ADDR_W = 10;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_BEYOND  = 2'd2
  } status_t;

  typedef struct packed {
    logic    clr_en;
    logic    req_load;
    logic    scan_start;
    logic    scan_run;
    logic    mark_load;
    logic    mark_run;
    logic    res_set;
    status_t res_status;
    logic    res_fit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_alloc;
    logic size_bad;
    logic free_beyond;
    logic free_empty;
    logic fit_hit;
    logic scan_end;
    logic mark_end;
  } sts_t;

endpackage

[src/first_fit_bitmap_allocator_core.sv]
// First-fit cell allocator over a used/free bitmap of CELL_COUNT cells.
// Input beat: tuser selects allocate or free, tdata carries size and start
// cell. One result beat per request: tuser is the status, tdata the start
// cell of an allocated block (zero otherwise).
// The bitmap sits in a RAM of 32-cell words, one word read per cycle.
// After an accepted input beat, a rejected request or a zero-size free goes
// straight to its result; a free runs a marking pass over the words that its
// range spans; an allocate first scans the words for a fit, then marks as
// for free; a failed allocate ends after scanning every word.
// The next request is taken once the result is handed to the output
// register; a result may wait there while the next request runs.
// After reset the block clears the RAM, one word per cycle, with
// in_tready low. When the receiver stalls, the result holds in the output
// register and a finished next result waits until that register frees.
module first_fit_bitmap_allocator_core
  import ffba_pkg::*;
#(
  parameter int CELL_COUNT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // block_size[10:0], free_address[20:11], zero pad
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // start_address[9:0], zero pad
  output logic [1:0]  out_tuser   // status
);

  cmd_t              cmd;
  sts_t              sts;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;

  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  ffba_dp #(
    .CELL_COUNT (CELL_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_tuser),
    .in_size    (in_tdata[10:0]),
    .in_addr    (in_tdata[20:11]),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (res_status),
    .out_addr   (res_addr)
  );

  assign out_tdata = {6'b0, res_addr};
  assign out_tuser = res_status;

endmodule

[src/ffba_dp.sv]
module ffba_dp
  import ffba_pkg::*;
#(
  parameter int CELL_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_func,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [ADDR_W-1:0] in_addr,
  input  cmd_t              cmd,
  output sts_t              sts,
  output status_t           out_status,
  output logic [ADDR_W-1:0] out_addr
);

  localparam int WORDS = (CELL_COUNT + WORD_W - 1) / WORD_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = WA_W + LOG_W;
  localparam int RUN_W = $clog2(CELL_COUNT + WORD_W + 1);
  localparam int CMP_W = (RUN_W > SIZE_W) ? RUN_W : SIZE_W;
  localparam int TAIL  = CELL_COUNT - (WORDS - 1) * WORD_W;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_data_r;

  logic              func_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;

  logic [WA_W-1:0]   rd_word_r;
  logic              iss_done_r;
  logic              ev_valid_r;
  logic [WA_W-1:0]   ev_word_r;
  logic [RUN_W-1:0]  run_r;
  logic [PW-1:0]     lo_r;
  logic [PW-1:0]     hi_r;
  status_t           res_status_r;
  logic              res_fit_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic              req_alloc;
  logic [WORD_W-1:0] used;
  logic [WORD_W-1:0] hv [LOG_W+1];
  logic [LOG_W-1:0]  lu [LOG_W+1][WORD_W];
  logic [WORD_W-1:0] hit;
  logic [LOG_W-1:0]  hit_idx;
  logic              hit_any;
  logic [RUN_W-1:0]  run_next;
  logic [PW-1:0]     fit_lo;
  logic [PW-1:0]     lo_src;
  logic [PW-1:0]     hi_src;
  logic [WA_W-1:0]   last_word;
  logic              issue;
  logic              mark_we;
  logic [LOG_W-1:0]  lo_b;
  logic [LOG_W-1:0]  hi_b;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] wdata;

  assign req_alloc = (func_r == FUNC_ALLOC);

  always_comb begin
    logic [LOG_W-1:0] span;
    logic [RUN_W-1:0] run_at;
    for (int j = 0; j < WORD_W; j++) begin
      used[j] = rd_data_r[j] | ((ev_word_r == LAST_WORD) && (j >= TAIL));
    end
    for (int j = 0; j < WORD_W; j++) begin
      hv[0][j] = used[j];
      lu[0][j] = LOG_W'(j);
    end
    for (int l = 0; l < LOG_W; l++) begin
      for (int j = 0; j < WORD_W; j++) begin
        hv[l+1][j] = hv[l][j];
        lu[l+1][j] = lu[l][j];
      end
      for (int j = (1 << l); j < WORD_W; j++) begin
        if (!hv[l][j] && hv[l][j-(1<<l)]) begin
          hv[l+1][j] = 1'b1;
          lu[l+1][j] = lu[l][j-(1<<l)];
        end
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      span = LOG_W'(j) - lu[LOG_W][j];
      if (hv[LOG_W][j]) begin
        run_at = RUN_W'(span);
      end else begin
        run_at = run_r + RUN_W'(j + 1);
      end
      hit[j] = CMP_W'(run_at) >= CMP_W'(size_r);
    end
    span = LOG_W'(WORD_W - 1) - lu[LOG_W][WORD_W-1];
    if (hv[LOG_W][WORD_W-1]) begin
      run_next = RUN_W'(span);
    end else begin
      run_next = run_r + RUN_W'(WORD_W);
    end
    hit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_idx = LOG_W'(j);
      end
    end
  end

  assign hit_any = |hit;
  assign fit_lo  = {ev_word_r, hit_idx} + PW'(1) - PW'(size_r);
  assign lo_src  = req_alloc ? fit_lo : PW'(addr_r);
  assign hi_src  = lo_src + PW'(size_r) - PW'(1);

  assign last_word = cmd.scan_run ? LAST_WORD : hi_r[PW-1:LOG_W];
  assign issue     = (cmd.scan_run | cmd.mark_run) & ~iss_done_r;
  assign mark_we   = cmd.mark_run & ev_valid_r;

  assign lo_b  = (ev_word_r == lo_r[PW-1:LOG_W]) ? lo_r[LOG_W-1:0] : '0;
  assign hi_b  = (ev_word_r == hi_r[PW-1:LOG_W]) ? hi_r[LOG_W-1:0] : LOG_W'(WORD_W - 1);
  assign mask  = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (LOG_W'(WORD_W - 1) - hi_b));
  assign wdata = req_alloc ? (rd_data_r | mask) : (rd_data_r & ~mask);

  assign sts.clr_done    = cmd.clr_en & (rd_word_r == LAST_WORD);
  assign sts.req_alloc   = req_alloc;
  assign sts.size_bad    = (size_r == '0) || (32'(size_r) > 32'(CELL_COUNT));
  assign sts.free_beyond = (32'(addr_r) + 32'(size_r)) > 32'(CELL_COUNT);
  assign sts.free_empty  = (size_r == '0);
  assign sts.fit_hit     = cmd.scan_run & ev_valid_r & hit_any;
  assign sts.scan_end    = cmd.scan_run & ev_valid_r & ~hit_any & (ev_word_r == LAST_WORD);
  assign sts.mark_end    = mark_we & (ev_word_r == hi_r[PW-1:LOG_W]);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[rd_word_r] <= '0;
    end else if (mark_we) begin
      mem[ev_word_r] <= wdata;
    end
    rd_data_r <= mem[rd_word_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_word_r  <= '0;
      iss_done_r <= 1'b0;
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= issue & ~cmd.scan_start & ~cmd.mark_load;
      if (cmd.clr_en) begin
        rd_word_r <= sts.clr_done ? '0 : rd_word_r + WA_W'(1);
      end else if (cmd.scan_start) begin
        rd_word_r  <= '0;
        iss_done_r <= 1'b0;
      end else if (cmd.mark_load) begin
        rd_word_r  <= lo_src[PW-1:LOG_W];
        iss_done_r <= 1'b0;
      end else if (issue) begin
        if (rd_word_r == last_word) begin
          iss_done_r <= 1'b1;
        end else begin
          rd_word_r <= rd_word_r + WA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_word_r <= rd_word_r;
    if (cmd.req_load) begin
      func_r <= in_func;
      size_r <= in_size;
      addr_r <= in_addr;
    end
    if (cmd.scan_start) begin
      run_r <= '0;
    end else if (cmd.scan_run && ev_valid_r) begin
      run_r <= run_next;
    end
    if (cmd.mark_load) begin
      lo_r <= lo_src;
      hi_r <= hi_src;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_fit_r    <= cmd.res_fit;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_fit_r ? ADDR_W'(lo_r) : '0;
    end
  end

  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;

endmodule

[src/ffba_ctrl.sv]
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic out_tready,
  output logic out_tvalid,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MARK  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_DONE;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.req_alloc) begin
          if (sts.size_bad) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_NO_ROOM;
            state_nxt      = S_RESP;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.free_beyond) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_BEYOND;
          state_nxt      = S_RESP;
        end else if (sts.free_empty) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_RESP;
        end else begin
          cmd.mark_load = 1'b1;
          state_nxt     = S_MARK;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.fit_hit) begin
          cmd.mark_load = 1'b1;
          state_nxt     = S_MARK;
        end else if (sts.scan_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_ROOM;
          state_nxt      = S_RESP;
        end
      end
      S_MARK: begin
        cmd.mark_run = 1'b1;
        if (sts.mark_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_DONE;
          cmd.res_fit    = sts.req_alloc;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

[tb/tb_first_fit_bitmap_allocator_core.sv]
module tb_first_fit_bitmap_allocator_core
  import ffba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS       = 1024;
  localparam int RAND_ITEMS  = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 120;

  class alloc_scoreboard;
    localparam int NCELLS = 1024;

    typedef struct {
      status_t           status;
      logic [ADDR_W-1:0] start;
    } alloc_result_t;

    typedef struct {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
    } live_block_t;

    bit [NCELLS-1:0] cell_used;
    alloc_result_t   expected_results[$];
    live_block_t     live_blocks[$];
    int              fail_count;

    function new();
      cell_used  = '0;
      fail_count = 0;
    endfunction

    task report_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      fail_count++;
    endtask

    function int used_cells();
      return $countones(cell_used);
    endfunction

    function int expected_count();
      return expected_results.size();
    endfunction

    task note_request(logic func, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      alloc_result_t res;
      live_block_t   blk;
      int            run;
      int            first;
      res.status = ST_DONE;
      res.start  = '0;
      if (func == FUNC_ALLOC) begin
        first = -1;
        run   = 0;
        if (size != 0 && int'(size) <= NCELLS) begin
          for (int i = 0; i < NCELLS; i++) begin
            if (cell_used[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == int'(size)) begin
                first = i + 1 - int'(size);
                break;
              end
            end
          end
        end
        if (first < 0) begin
          res.status = ST_NO_ROOM;
        end else begin
          for (int j = 0; j < int'(size); j++) cell_used[first + j] = 1'b1;
          res.start = first[ADDR_W-1:0];
          blk.start = first[ADDR_W-1:0];
          blk.size  = size;
          live_blocks.push_back(blk);
        end
      end else begin
        if (int'(addr) + int'(size) > NCELLS) begin
          res.status = ST_BEYOND;
        end else begin
          for (int j = 0; j < int'(size); j++) cell_used[int'(addr) + j] = 1'b0;
        end
      end
      expected_results.push_back(res);
    endtask

    task check_result(logic [1:0] status, logic [15:0] data);
      alloc_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0d addr %0d)",
                                  status, data[ADDR_W-1:0]));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (data[ADDR_W-1:0] !== want.start)
          report_mismatch($sformatf("start_address got %0d want %0d",
                                    data[ADDR_W-1:0], want.start));
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  alloc_scoreboard sb = new();
  bit steady      = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  first_fit_bitmap_allocator_core #(
    .CELL_COUNT(CELLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_first_fit_bitmap_allocator_core: FAIL");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || hold_active) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_alloc_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return SIZE_W'($urandom_range(1, 32));
    if (r < 85) return SIZE_W'($urandom_range(33, 160));
    if (r < 95) return SIZE_W'($urandom_range(161, 1024));
    if (r < 97) return '0;
    return SIZE_W'($urandom_range(1025, 2047));
  endfunction

  task automatic push_request(logic func, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {3'b000, addr, size};
    do @(posedge clk); while (!in_tready);
    sb.note_request(func, size, addr);
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_random_request();
    int r;
    int free_share;
    int idx;
    alloc_scoreboard::live_block_t blk;
    r = $urandom_range(0, 99);
    free_share = (sb.used_cells() > 600) ? 60 : 32;
    if (r < 8) begin
      push_request(1'($urandom_range(0, 1)),
                   ($urandom_range(0, 1) != 0) ? SIZE_W'($urandom_range(0, 2047))
                                               : SIZE_W'($urandom_range(0, 64)),
                   ADDR_W'($urandom_range(0, 1023)));
    end else if (r < 8 + free_share && sb.live_blocks.size() > 0) begin
      idx = $urandom_range(0, sb.live_blocks.size() - 1);
      blk = sb.live_blocks[idx];
      sb.live_blocks.delete(idx);
      push_request(FUNC_FREE, blk.size, blk.start);
    end else begin
      push_request(FUNC_ALLOC, pick_alloc_size(), ADDR_W'($urandom_range(0, 1023)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  initial begin
    int run_len;
    int stall_len;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        run_len = steady ? 20 : $urandom_range(1, 12);
        out_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        stall_len = idle_len();
        if (stall_len > 0) begin
          out_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(FUNC_ALLOC, 11'd0,    10'd0);
    push_request(FUNC_ALLOC, 11'd1025, 10'd0);
    push_request(FUNC_ALLOC, 11'd2047, 10'd1023);
    push_request(FUNC_ALLOC, 11'd1024, 10'd0);
    push_request(FUNC_ALLOC, 11'd1,    10'd0);
    push_request(FUNC_FREE,  11'd1024, 10'd0);
    push_request(FUNC_FREE,  11'd2,    10'd1023);
    push_request(FUNC_FREE,  11'd1,    10'd1023);
    push_request(FUNC_FREE,  11'd0,    10'd1023);
    push_request(FUNC_FREE,  11'd0,    10'd512);
    push_request(FUNC_ALLOC, 11'd1,    10'd0);
    push_request(FUNC_ALLOC, 11'd31,   10'd0);
    push_request(FUNC_ALLOC, 11'd40,   10'd0);
    push_request(FUNC_FREE,  11'd31,   10'd1);
    push_request(FUNC_ALLOC, 11'd32,   10'd0);
    push_request(FUNC_ALLOC, 11'd20,   10'd0);
    push_request(FUNC_FREE,  11'd50,   10'd900);
    push_request(FUNC_FREE,  11'd2047, 10'd0);
    push_request(FUNC_FREE,  11'd1024, 10'd1023);
    push_request(FUNC_ALLOC, 11'd1024, 10'd0);
    push_request(FUNC_ALLOC, 11'd900,  10'd0);
    push_request(FUNC_FREE,  11'd1024, 10'd0);
    sb.live_blocks.delete();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 250) begin
        in_tvalid <= 1'b0;
        while (sb.expected_count() != 0) @(posedge clk);
      end
      steady = (n >= 300 && n < 380);
      push_random_request();
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    while (sb.expected_count() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_count() == 0) begin
      $display("tb_first_fit_bitmap_allocator_core: PASS");
    end else begin
      $display("tb_first_fit_bitmap_allocator_core: FAIL");
    end
    $finish;
  end

endmodule

[first_fit_bitmap_allocator_core.f]
src/ffba_pkg.sv
src/ffba_dp.sv
src/ffba_ctrl.sv
src/first_fit_bitmap_allocator_core.sv
tb/tb_first_fit_bitmap_allocator_core.sv
